// ----- sv/dspr_pkg.sv -----
// Shared constants and decode helpers for the pad protocol responder.
`timescale 1ns / 1ps
`default_nettype none

package dspr_pkg;

   // Number of pads served; the select field addresses one of them.
   localparam int NumPads = 2;
   localparam int PadW    = (NumPads > 1) ? $clog2(NumPads) : 1;

   // Command bytes.
   localparam logic [7:0] CmdInitPressure = 8'h40;
   localparam logic [7:0] CmdQueryMask    = 8'h41;
   localparam logic [7:0] CmdPoll         = 8'h42;
   localparam logic [7:0] CmdConfig       = 8'h43;
   localparam logic [7:0] CmdSetMode      = 8'h44;
   localparam logic [7:0] CmdQueryModel   = 8'h45;
   localparam logic [7:0] CmdQueryAct     = 8'h46;
   localparam logic [7:0] CmdQueryComb    = 8'h47;
   localparam logic [7:0] CmdQueryMode    = 8'h4C;
   localparam logic [7:0] CmdVibration    = 8'h4D;
   localparam logic [7:0] CmdSetPressure  = 8'h4F;

   // Pad identities and fixed reply bytes.
   localparam logic [7:0] PadIdDigital = 8'h41;
   localparam logic [7:0] PadIdAnalog  = 8'h73;
   localparam logic [7:0] PadIdDs2     = 8'h79;
   localparam logic [7:0] ReplyConfig  = 8'hF3;
   localparam logic [7:0] ReplyAck     = 8'h5A;

   // Frame lengths in bytes.
   localparam logic [4:0] FrameLenNone    = 5'd0;
   localparam logic [4:0] FrameLenDigital = 5'd4;
   localparam logic [4:0] FrameLenStd     = 5'd8;
   localparam logic [4:0] FrameLenDs2     = 5'd20;

   // Reset and argument values of the stored reply constants.
   localparam logic [23:0] Const1TailA = 24'h02000A;
   localparam logic [23:0] Const1TailB = 24'h010114;
   localparam logic [7:0]  Const3ByteA = 8'h04;
   localparam logic [7:0]  Const3ByteB = 8'h07;

   // Button bit that gates each of the twelve pressure bytes of a poll.
   function automatic logic [3:0] press_bit(input logic [3:0] idx);
      logic [3:0] bit_no;
      unique case (idx)
         4'd0:    bit_no = 4'd13;
         4'd1:    bit_no = 4'd15;
         4'd2:    bit_no = 4'd12;
         4'd3:    bit_no = 4'd14;
         4'd4:    bit_no = 4'd4;
         4'd5:    bit_no = 4'd5;
         4'd6:    bit_no = 4'd6;
         4'd7:    bit_no = 4'd7;
         4'd8:    bit_no = 4'd2;
         4'd9:    bit_no = 4'd3;
         4'd10:   bit_no = 4'd0;
         4'd11:   bit_no = 4'd1;
         default: bit_no = 4'd0;
      endcase
      return bit_no;
   endfunction

endpackage

`default_nettype wire

// ----- sv/dualshock_pad_protocol_responder.sv -----
// Top level of the controller-side pad protocol responder.
`timescale 1ns / 1ps
`default_nettype none

// The responder answers every byte sent by the console with exactly one reply byte, on
// behalf of up to two pads, each with its own protocol state. A transaction on the req_
// channel carries the console byte, a start-of-frame flag, the pad select and the live
// pad inputs (buttons, sticks, pressure); after acceptance the byte is held in the input
// register and its reply is then loaded into the output register, which presents it as
// one transaction on the rsp_ channel. While req_stall is low, one transaction can be
// accepted in every cycle: the input register feeds a single stage of decode logic
// whose result lands in the output register, and the per-pad state is updated in that
// same step, so consecutive bytes of a frame see each other's effects without any
// bubble. While req_stall is low the rate is therefore one transaction per clock, set
// by the single decode step; rsp_stall propagates combinationally to req_stall only
// when both the input register and the output register are occupied.
module dualshock_pad_protocol_responder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_frame_start,
   input  wire logic        req_pad_select,
   input  wire logic [7:0]  req_tx_byte,
   input  wire logic [15:0] req_buttons,
   input  wire logic [7:0]  req_left_x,
   input  wire logic [7:0]  req_left_y,
   input  wire logic [7:0]  req_right_x,
   input  wire logic [7:0]  req_right_y,
   input  wire logic [7:0]  req_pressure_level,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_rx_byte
);
   import dspr_pkg::*;

   // Input register.
   logic        s1_valid_ff, s1_valid_in;
   logic        s1_frame_start_ff;
   logic        s1_pad_select_ff;
   logic [7:0]  s1_tx_byte_ff;
   logic [55:0] s1_snapshot_ff;

   // Output register.
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_rx_byte_ff, out_rx_byte_in;

   // Per-pad protocol state.
   logic [4:0]  byte_index_ff     [NumPads];
   logic [4:0]  byte_index_in     [NumPads];
   logic [4:0]  frame_length_ff   [NumPads];
   logic [4:0]  frame_length_in   [NumPads];
   logic [7:0]  active_command_ff [NumPads];
   logic [7:0]  active_command_in [NumPads];
   logic [7:0]  pad_id_ff         [NumPads];
   logic [7:0]  pad_id_in         [NumPads];
   logic [7:0]  pad_mode_ff       [NumPads];
   logic [7:0]  pad_mode_in       [NumPads];
   logic        native_ds2_ff     [NumPads];
   logic        native_ds2_in     [NumPads];
   logic        config_mode_ff    [NumPads];
   logic        config_mode_in    [NumPads];
   logic [23:0] const1_tail_ff    [NumPads];
   logic [23:0] const1_tail_in    [NumPads];
   logic [7:0]  const3_byte_ff    [NumPads];
   logic [7:0]  const3_byte_in    [NumPads];
   logic [55:0] poll_snapshot_ff  [NumPads];
   logic [55:0] poll_snapshot_in  [NumPads];

   logic out_load;
   logic req_accept;
   logic s1_fire;

   // The output register can take a new reply when it is empty or being emptied.
   assign out_load   = !out_valid_ff || !rsp_stall;
   assign req_stall  = s1_valid_ff && !out_load;
   assign req_accept = req_valid && !req_stall;
   assign s1_fire    = s1_valid_ff && out_load;

   assign s1_valid_in  = req_accept || (s1_valid_ff && !out_load);
   assign out_valid_in = out_load ? s1_valid_ff : 1'b1;

   assign rsp_valid   = out_valid_ff;
   assign rsp_rx_byte = out_rx_byte_ff;

   // Decode of the byte in the input register against the addressed pad's state.
   always_comb begin
      logic [PadW-1:0] pad;
      logic [4:0]      k;
      logic [7:0]      cmd;
      logic [7:0]      tx;
      logic [55:0]     snap;
      logic [15:0]     btn;
      logic            cfg_eff;
      logic [4:0]      press_idx;
      logic [7:0]      rx;

      for (int i = 0; i < NumPads; i++) begin
         byte_index_in[i]     = byte_index_ff[i];
         frame_length_in[i]   = frame_length_ff[i];
         active_command_in[i] = active_command_ff[i];
         pad_id_in[i]         = pad_id_ff[i];
         pad_mode_in[i]       = pad_mode_ff[i];
         native_ds2_in[i]     = native_ds2_ff[i];
         config_mode_in[i]    = config_mode_ff[i];
         const1_tail_in[i]    = const1_tail_ff[i];
         const3_byte_in[i]    = const3_byte_ff[i];
         poll_snapshot_in[i]  = poll_snapshot_ff[i];
      end

      // A select beyond the last pad addresses the last pad.
      if (int'(s1_pad_select_ff) >= NumPads) begin
         pad = PadW'(NumPads - 1);
      end else begin
         pad = PadW'(s1_pad_select_ff);
      end

      tx        = s1_tx_byte_ff;
      cmd       = active_command_ff[pad];
      k         = s1_frame_start_ff ? 5'd0 : byte_index_ff[pad];
      snap      = poll_snapshot_ff[pad];
      btn       = snap[15:0];
      press_idx = k - 5'd8;
      rx        = 8'h00;

      // The configuration argument arrives at byte two and already shapes that byte's reply.
      cfg_eff = config_mode_ff[pad];
      if (cmd == CmdConfig && k == 5'd2 && tx <= 8'd1) begin
         cfg_eff = tx[0];
      end

      if (k == 5'd0) begin
         // Command byte: opens a frame.
         active_command_in[pad] = tx;
         byte_index_in[pad]     = 5'd1;
         frame_length_in[pad]   = FrameLenStd;
         rx                     = ReplyConfig;
         unique case (tx)
            CmdInitPressure, CmdQueryMask, CmdSetMode, CmdQueryModel,
            CmdQueryAct, CmdQueryComb, CmdQueryMode, CmdVibration: begin
               rx = ReplyConfig;
            end
            CmdConfig: begin
               rx = config_mode_ff[pad] ? ReplyConfig : pad_id_ff[pad];
            end
            CmdSetPressure: begin
               pad_id_in[pad]     = PadIdDs2;
               native_ds2_in[pad] = 1'b1;
            end
            CmdPoll: begin
               poll_snapshot_in[pad] = s1_snapshot_ff;
               if (pad_id_ff[pad] == PadIdDs2) begin
                  frame_length_in[pad] = FrameLenDs2;
               end else if (pad_id_ff[pad] == PadIdAnalog) begin
                  frame_length_in[pad] = FrameLenStd;
               end else begin
                  frame_length_in[pad] = FrameLenDigital;
               end
               rx = pad_id_ff[pad];
            end
            default: begin
               // Unknown command: the rest of the frame answers zero.
               frame_length_in[pad] = FrameLenNone;
               rx                   = 8'h00;
            end
         endcase
      end else begin
         if (k == 5'd2) begin
            unique case (cmd)
               CmdConfig: begin
                  if (tx <= 8'd1) config_mode_in[pad] = tx[0];
               end
               CmdSetMode: begin
                  pad_mode_in[pad] = tx;
                  if (tx == 8'd0) begin
                     pad_id_in[pad] = PadIdDigital;
                  end else if (tx == 8'd1) begin
                     pad_id_in[pad] = native_ds2_ff[pad] ? PadIdDs2 : PadIdAnalog;
                  end
               end
               CmdQueryAct: begin
                  if (tx == 8'd0) begin
                     const1_tail_in[pad] = Const1TailA;
                  end else if (tx == 8'd1) begin
                     const1_tail_in[pad] = Const1TailB;
                  end
               end
               CmdQueryMode: begin
                  if (tx == 8'd0) begin
                     const3_byte_in[pad] = Const3ByteA;
                  end else if (tx == 8'd1) begin
                     const3_byte_in[pad] = Const3ByteB;
                  end
               end
               default: begin
               end
            endcase
         end

         if (k < frame_length_ff[pad]) begin
            byte_index_in[pad] = k + 5'd1;
            if (k == 5'd1) begin
               rx = ReplyAck;
            end else begin
               unique case (cmd)
                  CmdInitPressure: begin
                     if (k == 5'd4) rx = 8'h02;
                     else if (k == 5'd7) rx = ReplyAck;
                  end
                  CmdQueryMask: begin
                     if (k == 5'd2 || k == 5'd3) rx = 8'hFF;
                     else if (k == 5'd4) rx = 8'h03;
                     else if (k == 5'd7) rx = ReplyAck;
                  end
                  CmdPoll: begin
                     unique case (k)
                        5'd2: rx = btn[15:8];
                        5'd3: rx = btn[7:0];
                        5'd4: rx = snap[23:16];
                        5'd5: rx = snap[31:24];
                        5'd6: rx = snap[39:32];
                        5'd7: rx = snap[47:40];
                        default: begin
                           // Pressure bytes: each carries the pressure level when its button bit is low, else zero.
                           if (k >= 5'd8 && k < 5'd20 && !btn[press_bit(press_idx[3:0])]) begin
                              rx = snap[55:48];
                           end
                        end
                     endcase
                  end
                  CmdConfig: begin
                     if ((k == 5'd2 || k == 5'd3) && cfg_eff) rx = 8'hFF;
                  end
                  CmdQueryModel: begin
                     unique case (k)
                        5'd2:    rx = 8'h03;
                        5'd3:    rx = 8'h02;
                        5'd4:    rx = pad_mode_ff[pad];
                        5'd5:    rx = 8'h02;
                        5'd6:    rx = 8'h01;
                        default: rx = 8'h00;
                     endcase
                  end
                  CmdQueryAct: begin
                     unique case (k)
                        5'd4:    rx = 8'h01;
                        5'd5:    rx = const1_tail_ff[pad][23:16];
                        5'd6:    rx = const1_tail_ff[pad][15:8];
                        5'd7:    rx = const1_tail_ff[pad][7:0];
                        default: rx = 8'h00;
                     endcase
                  end
                  CmdQueryComb: begin
                     if (k == 5'd4) rx = 8'h02;
                     else if (k == 5'd6) rx = 8'h01;
                  end
                  CmdQueryMode: begin
                     if (k == 5'd5) rx = const3_byte_ff[pad];
                  end
                  CmdVibration: begin
                     rx = 8'hFF;
                  end
                  CmdSetPressure: begin
                     if (k == 5'd7) rx = ReplyAck;
                  end
                  default: begin
                     rx = 8'h00;
                  end
               endcase
            end
         end
      end

      out_rx_byte_in = rx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (req_accept) begin
         s1_frame_start_ff <= req_frame_start;
         s1_pad_select_ff  <= req_pad_select;
         s1_tx_byte_ff     <= req_tx_byte;
         s1_snapshot_ff    <= {req_pressure_level, req_left_y, req_left_x,
                               req_right_y, req_right_x, req_buttons};
      end
      if (s1_fire) begin
         out_rx_byte_ff <= out_rx_byte_in;
      end
   end

   // Protocol state changes only as a byte moves into the output register.
   always_ff @(posedge clock) begin
      for (int i = 0; i < NumPads; i++) begin
         if (reset) begin
            byte_index_ff[i]     <= 5'd0;
            frame_length_ff[i]   <= FrameLenNone;
            active_command_ff[i] <= 8'h00;
            pad_id_ff[i]         <= PadIdDigital;
            pad_mode_ff[i]       <= 8'h00;
            native_ds2_ff[i]     <= 1'b0;
            config_mode_ff[i]    <= 1'b0;
            const1_tail_ff[i]    <= Const1TailA;
            const3_byte_ff[i]    <= 8'h00;
         end else if (s1_fire) begin
            byte_index_ff[i]     <= byte_index_in[i];
            frame_length_ff[i]   <= frame_length_in[i];
            active_command_ff[i] <= active_command_in[i];
            pad_id_ff[i]         <= pad_id_in[i];
            pad_mode_ff[i]       <= pad_mode_in[i];
            native_ds2_ff[i]     <= native_ds2_in[i];
            config_mode_ff[i]    <= config_mode_in[i];
            const1_tail_ff[i]    <= const1_tail_in[i];
            const3_byte_ff[i]    <= const3_byte_in[i];
         end
         if (s1_fire) begin
            poll_snapshot_ff[i] <= poll_snapshot_in[i];
         end
      end
   end

   // The input side is held back only when both registers are full and the output stalls.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && out_valid_ff && rsp_stall))
      else $error("input stalled without a full pipeline");

   for (genvar g = 0; g < NumPads; g++) begin : g_pad_checks
      // A pad only ever reports one of its three identities.
      assert property (@(posedge clock) disable iff (reset)
         pad_id_ff[g] == PadIdDigital || pad_id_ff[g] == PadIdAnalog ||
         pad_id_ff[g] == PadIdDs2)
         else $error("pad identity corrupted");

      // The pressure identity needs the native mode to have been enabled first.
      assert property (@(posedge clock) disable iff (reset)
         !native_ds2_ff[g] |-> pad_id_ff[g] != PadIdDs2)
         else $error("pressure identity without native mode");

      // The byte count never runs past the longest frame.
      assert property (@(posedge clock) disable iff (reset)
         byte_index_ff[g] <= FrameLenDs2)
         else $error("byte index beyond longest frame");
   end

endmodule

`default_nettype wire
